### design/heq_pkg.sv
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Shared constants, table entry layout and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package heq_pkg;

	localparam int NCHAN      = 3;
	localparam int PIX_W      = 8;
	localparam int NBINS      = 256;
	localparam int DIM_W      = 13;
	localparam int MAX_DIM    = 4096;
	localparam int DIM_RESET  = 256;
	localparam int PROD_W     = 25;
	localparam int CNT_W      = 25;
	localparam int AVG_W      = 17;
	localparam int DVD_W      = 26;
	localparam int LVL_W      = 9;
	localparam int QUO_W      = 20;
	localparam int DIV_STEPS  = DVD_W;
	localparam int DCNT_W     = 5;
	localparam int QUOTA_PAD  = 100;
	localparam int LAST_MULT  = 10;
	localparam int TOP_LEVEL  = 255;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Operation codes of an input item.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_BUILD = 2'd2;
	localparam logic [1:0] OP_MAP   = 2'd3;

	// One mapping table entry of one channel.
	typedef struct packed {
		logic [LVL_W-1:0] nxt;
		logic [QUO_W-1:0] qhi;
		logic [QUO_W-1:0] qlo;
		logic [7:0]       high;
		logic [7:0]       low;
	} tab_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ld;
		logic use_bin;
		logic cnt_clr;
		logic cnt_rd;
		logic cnt_wr;
		logic tab_rd;
		logic tab_wr;
		logic out_ld;
		logic avg_ld;
		logic avg_set;
		logic b_init;
		logic div_start;
		logic div_step;
		logic b_step;
		logic bin_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bin_last;
		logic div_last;
	} status_t;

endpackage

### design/heq_datapath.sv
// ----------------------------------------------------------------------------
// Histogram equalizer datapath
// Configuration registers, per-channel histogram and mapping memories,
// the bit-serial dividers of the table build and the output register.
// ----------------------------------------------------------------------------
module heq_datapath
	import heq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [DIM_W-1:0]       cfg_data,
	input  logic [NCHAN*PIX_W-1:0] pix_in,   // red, green, blue from the lowest bit up
	input  cmd_t                   cmd,
	output status_t                status,
	output logic [NCHAN*PIX_W-1:0] pix_out   // red, green, blue from the lowest bit up
);

	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  width_cl, height_cl;
	logic [PROD_W-1:0] prod_s1;
	logic [AVG_W-1:0]  avg_q;
	logic [7:0]        bin_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(DIM_RESET);
			height_q <= DIM_W'(DIM_RESET);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions are clamped to the supported range.
	always_comb begin
		width_cl  = width_q;
		height_cl = height_q;
		if (width_q == '0) width_cl = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_DIM)) width_cl = DIM_W'(MAX_DIM);
		if (height_q == '0) height_cl = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_DIM)) height_cl = DIM_W'(MAX_DIM);
	end

	// Average pixels per level: image area over 256, at least one.
	always_ff @(posedge clk) begin
		if (cmd.avg_ld) prod_s1 <= PROD_W'(width_cl) * PROD_W'(height_cl);
		if (cmd.avg_set) begin
			if (prod_s1[PROD_W-1:8] == '0) avg_q <= AVG_W'(1);
			else avg_q <= prod_s1[PROD_W-1:8];
		end
	end

	// Bin counter for the clearing sweep and the build walk, and the divider step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.bin_inc) bin_q <= bin_q + 8'd1;
			if (cmd.div_start) div_cnt_q <= '0;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	assign status.bin_last = &bin_q;
	assign status.div_last = (div_cnt_q == DCNT_W'(DIV_STEPS - 1));

	for (genvar c = 0; c < NCHAN; c++) begin : g_chan
		logic [CNT_W-1:0]  cnt_mem [NBINS];
		tab_t              tab_mem [NBINS];
		logic [PIX_W-1:0]  pix_q;
		logic [7:0]        addr;
		logic [CNT_W-1:0]  cnt_rd_q;
		tab_t              tab_rd_q;
		logic [LVL_W-1:0]  lvl_q;
		logic [AVG_W-1:0]  rest_q;
		logic [AVG_W-1:0]  rem_q;
		logic [DVD_W-1:0]  dvd_q;
		logic [AVG_W:0]    trial;
		logic [PIX_W-1:0]  out_q;
		logic [LVL_W-1:0]  cur;
		logic [QUO_W-1:0]  qh, ql;
		tab_t              map_ent, bld_ent, wr_ent;
		logic [9:0]        hi_sum;
		logic [LVL_W-1:0]  hi_sat;
		logic [QUO_W-1:0]  avg_pad;

		assign addr = cmd.use_bin ? bin_q : pix_q;

		always_ff @(posedge clk) begin
			if (cmd.in_ld) pix_q <= pix_in[c*PIX_W +: PIX_W];
		end

		// Histogram memory: clearing sweep and saturating increment.
		always_ff @(posedge clk) begin
			if (cmd.cnt_rd) cnt_rd_q <= cnt_mem[addr];
			if (cmd.cnt_clr) cnt_mem[bin_q] <= '0;
			else if (cmd.cnt_wr && !(&cnt_rd_q)) cnt_mem[addr] <= cnt_rd_q + CNT_W'(1);
		end

		// Mapping table memory.
		always_ff @(posedge clk) begin
			if (cmd.tab_rd) tab_rd_q <= tab_mem[addr];
			if (cmd.tab_wr) tab_mem[addr] <= wr_ent;
		end

		// Map update: pick the next level within the quotas of the two end levels.
		always_comb begin
			cur = tab_rd_q.nxt;
			qh  = tab_rd_q.qhi;
			ql  = tab_rd_q.qlo;
			if (cur == {1'b0, tab_rd_q.high}) begin
				if (qh == '0) cur = {1'b0, tab_rd_q.low};
				else qh = qh - QUO_W'(1);
			end
			if (cur == {1'b0, tab_rd_q.low}) begin
				if (ql == '0) cur = {1'b0, tab_rd_q.low} + LVL_W'(1);
				else ql = ql - QUO_W'(1);
			end
			if (cur > {1'b0, tab_rd_q.high}) cur = {1'b0, tab_rd_q.low};
			map_ent      = tab_rd_q;
			map_ent.qhi  = qh;
			map_ent.qlo  = ql;
			map_ent.nxt  = cur + LVL_W'(1);
		end

		// Build entry from the running level, the carry and the finished division.
		always_comb begin
			avg_pad = QUO_W'(avg_q) + QUO_W'(QUOTA_PAD);
			hi_sum  = 10'(lvl_q) + 10'(dvd_q[8:0]);
			if (dvd_q[DVD_W-1:9] != '0 || hi_sum >= 10'(NBINS)) hi_sat = LVL_W'(NBINS);
			else hi_sat = hi_sum[LVL_W-1:0];
			bld_ent.low  = (lvl_q > LVL_W'(TOP_LEVEL)) ? 8'(TOP_LEVEL) : lvl_q[7:0];
			bld_ent.qlo  = (rest_q != '0) ? QUO_W'(avg_q) - QUO_W'(rest_q) : avg_pad;
			bld_ent.high = (hi_sat > LVL_W'(TOP_LEVEL)) ? 8'(TOP_LEVEL) : hi_sat[7:0];
			bld_ent.qhi  = (rem_q != '0) ? QUO_W'(rem_q) : avg_pad;
			bld_ent.nxt  = {1'b0, bld_ent.low};
			if (status.bin_last) begin
				bld_ent.high = 8'(TOP_LEVEL);
				bld_ent.qhi  = QUO_W'(avg_q) * QUO_W'(LAST_MULT);
			end
			wr_ent = cmd.use_bin ? bld_ent : map_ent;
		end

		// Restoring divider, one quotient bit a cycle; the quotient shifts into dvd_q.
		assign trial = {rem_q, dvd_q[DVD_W-1]};

		always_ff @(posedge clk) begin
			if (cmd.b_init) begin
				lvl_q  <= '0;
				rest_q <= '0;
			end else if (cmd.b_step) begin
				lvl_q  <= hi_sat;
				rest_q <= rem_q;
			end
			if (cmd.div_start) begin
				dvd_q <= DVD_W'(rest_q) + DVD_W'(cnt_rd_q);
				rem_q <= '0;
			end else if (cmd.div_step) begin
				if (trial >= {1'b0, avg_q}) begin
					rem_q <= AVG_W'(trial - {1'b0, avg_q});
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[AVG_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				end
			end
		end

		// Output register.
		always_ff @(posedge clk) begin
			if (cmd.out_ld) out_q <= cur[7:0];
		end

		assign pix_out[c*PIX_W +: PIX_W] = out_q;
	end

endmodule

### design/heq_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram equalizer controller
// Sequences clear sweeps, count and map read-modify-writes and the table
// build walk, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module heq_ctrl
	import heq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  status_t    status,
	output cmd_t       cmd
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CRD  = 4'd2;
	localparam logic [3:0] S_CWR  = 4'd3;
	localparam logic [3:0] S_MRD  = 4'd4;
	localparam logic [3:0] S_MWR  = 4'd5;
	localparam logic [3:0] S_AVG  = 4'd6;
	localparam logic [3:0] S_AVG2 = 4'd7;
	localparam logic [3:0] S_BRD  = 4'd8;
	localparam logic [3:0] S_BST  = 4'd9;
	localparam logic [3:0] S_BDIV = 4'd10;
	localparam logic [3:0] S_BWR  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.use_bin = 1'b1;
				cmd.cnt_clr = 1'b1;
				cmd.bin_inc = 1'b1;
				if (status.bin_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_ld = 1'b1;
					unique case (op)
						OP_CLEAR: state_d = S_CLR;
						OP_COUNT: state_d = S_CRD;
						OP_BUILD: state_d = S_AVG;
						OP_MAP:   state_d = S_MRD;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_CRD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_CWR;
			end
			S_CWR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_MRD: begin
				cmd.tab_rd = 1'b1;
				state_d    = S_MWR;
			end
			S_MWR: begin
				if (out_free) begin
					cmd.tab_wr = 1'b1;
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_AVG: begin
				cmd.avg_ld = 1'b1;
				state_d    = S_AVG2;
			end
			S_AVG2: begin
				cmd.avg_set = 1'b1;
				cmd.b_init  = 1'b1;
				state_d     = S_BRD;
			end
			S_BRD: begin
				cmd.use_bin = 1'b1;
				cmd.cnt_rd  = 1'b1;
				state_d     = S_BST;
			end
			S_BST: begin
				cmd.use_bin   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = S_BDIV;
			end
			S_BDIV: begin
				cmd.use_bin  = 1'b1;
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = S_BWR;
			end
			S_BWR: begin
				cmd.use_bin = 1'b1;
				cmd.tab_wr  = 1'b1;
				cmd.b_step  = 1'b1;
				cmd.bin_inc = 1'b1;
				state_d     = status.bin_last ? S_IDLE : S_BRD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### design/histogram_equalizer_rgb.sv
// ----------------------------------------------------------------------------
// Histogram equalizer for RGB pixels
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// A count item reads and then rewrites one histogram bin per channel. A map item
// reads the table, then updates it and loads the output register, which waits
// while an earlier result is not taken. A clear item sweeps the three 256-entry
// histogram memories, one bin a cycle; the same sweep runs after reset before
// the first item is accepted. A build item sets up the average and then, for
// each bin, the three channels read their own histograms at the same bin and
// run their own restoring dividers, one quotient bit a cycle over 26 bits.
module histogram_equalizer_rgb
	import heq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // op[1:0], red_in[9:2], green_in[17:10], blue_in[25:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [12:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	heq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.op        (s_axis_tdata[1:0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	heq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.pix_in   (s_axis_tdata[25:2]),
		.cmd      (cmd),
		.status   (status),
		.pix_out  (m_axis_tdata)
	);

endmodule
